// File: src/assert_macros.svh
// Assertion macros used by the checker file of the button press classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: a implies b");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: a implies b next cycle");

// Next-cycle implication that is also checked during reset.
`define ASSERT_NEXT_ALWAYS(label, clk, a, b) \
    label: assert property (@(posedge clk) (a) |=> (b)) \
        else $error("assertion failed: a implies b next cycle");

`endif

// File: src/bpc_pkg.sv
// Package of the button press classifier: codes, reset values and shared types.
package bpc_pkg;

    // Event codes carried in the result stream.
    typedef enum logic [1:0] {
        EV_SHORT   = 2'd0,
        EV_LONG    = 2'd1,
        EV_RELEASE = 2'd2
    } event_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_LONG     = 2'd1;
    localparam logic [1:0] REG_POLL     = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [7:0]  DEBOUNCE_RESET = 8'd50;
    localparam logic [15:0] LONG_RESET     = 16'd1000;
    localparam logic [7:0]  POLL_RESET     = 8'd20;

    // Default width of the hold counter.
    localparam int TIME_WIDTH_DEFAULT = 16;

    // Port widths.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int REPORT_W    = 16;

    // One entry of the result queue.
    typedef struct packed {
        logic                last;
        logic [REPORT_W-1:0] held_time;
        event_t              code;
    } result_t;

endpackage

// File: src/button_press_classifier_unit.sv
// Top level of the button press classifier: debounce, poll and press classification.
//
//   channel   direction  transfer when          payload
//   s_*       in         s_tvalid & s_tready    tdata[0] button_level
//   m_*       out        m_tvalid & m_tready    tdata event_code, held_time_ms; tlast
//   cfg_*     in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
// One tick is taken per cycle while the queue has room; it is held in the input register and
// then classified in a single pass, writing zero to two entries into a four-entry result queue.
// A tick that produces two events drains as two output transfers.
// The input register holds its tick while the queue has room for fewer than two entries.
// Reset is synchronous; there is no clearing pass.
module button_press_classifier_unit #(
    parameter int TIME_WIDTH = bpc_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input stream: [0] button_level, [7:1] zero.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bpc_pkg::IN_TDATA_W-1:0]   s_tdata,
    // Result stream: [1:0] event_code, [17:2] held_time_ms, [23:18] zero.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bpc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tlast,
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bpc_pkg::*;

    localparam int CW = (TIME_WIDTH > REPORT_W) ? TIME_WIDTH : REPORT_W;
    localparam logic [TIME_WIDTH-1:0] CNT_MAX = {TIME_WIDTH{1'b1}};
    localparam int QDEPTH = 4;
    localparam int QPW = $clog2(QDEPTH);

    // Configuration registers.
    logic [7:0]  debounce_reg;
    logic [15:0] long_reg;
    logic [7:0]  poll_reg;

    // Input register.
    logic in_valid_reg;
    logic in_level_reg;

    // Classifier state.
    logic                  prev_level_reg, prev_level_next;
    logic                  edge_pending_reg, edge_pending_next;
    logic [7:0]            poll_cd_reg, poll_cd_next;
    logic [7:0]            deb_cd_reg, deb_cd_next;
    logic                  debouncing_reg, debouncing_next;
    logic                  held_reg, held_next;
    logic                  long_rep_reg, long_rep_next;
    logic [TIME_WIDTH-1:0] cnt_reg, cnt_next;

    // Result queue.
    result_t          q_reg [QDEPTH];
    logic [QPW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPW:0]     q_count_reg, q_count_next;

    // Per-tick work signals.
    logic            process;
    logic            pop;
    logic            do_body;
    logic            do_sample;
    logic            lvl;
    logic [1:0]      res_n;
    event_t          code0, code1;
    logic [REPORT_W-1:0] held_rep;
    logic [CW-1:0]   cnt_ext;
    logic [QPW-1:0]  wr_ptr_p1;

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign process   = in_valid_reg && (q_count_reg <= (QPW+1)'(QDEPTH - 2));
    assign s_tready  = !in_valid_reg || process;
    assign pop       = m_tvalid && m_tready;
    assign lvl       = in_level_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
            long_reg     <= LONG_RESET;
            poll_reg     <= POLL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DEBOUNCE: debounce_reg <= cfg_data[7:0];
                REG_LONG:     long_reg     <= cfg_data;
                REG_POLL:     poll_reg     <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    // Input register: loads on every input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_level_reg <= s_tdata[0];
        end
    end

    // Single-pass classification of the registered tick.
    always_comb begin
        prev_level_next   = lvl;
        edge_pending_next = edge_pending_reg || (prev_level_reg && !lvl);
        poll_cd_next      = poll_cd_reg;
        deb_cd_next       = deb_cd_reg;
        debouncing_next   = debouncing_reg;
        held_next         = held_reg;
        long_rep_next     = long_rep_reg;
        cnt_next          = (held_reg && cnt_reg != CNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;
        do_body           = 1'b0;
        do_sample         = 1'b0;
        res_n             = 2'd0;
        code0             = EV_SHORT;
        code1             = EV_RELEASE;

        // Choose between debounce wait, poll countdown, a pending edge and a poll.
        if (debouncing_reg) begin
            if (deb_cd_reg > 8'd1) begin
                deb_cd_next = deb_cd_reg - 8'd1;
            end else begin
                debouncing_next = 1'b0;
                deb_cd_next     = 8'd0;
                do_body         = 1'b1;
                do_sample       = 1'b1;
            end
        end else if (poll_cd_reg != 8'd0) begin
            poll_cd_next = poll_cd_reg - 8'd1;
        end else if (edge_pending_next) begin
            edge_pending_next = 1'b0;
            if (debounce_reg == 8'd0) begin
                do_body   = 1'b1;
                do_sample = 1'b1;
            end else begin
                debouncing_next = 1'b1;
                deb_cd_next     = debounce_reg;
            end
        end else begin
            do_body = 1'b1;
        end

        // Poll body: confirm a press, then check a held button.
        if (do_body) begin
            if (do_sample && !lvl && !held_reg) begin
                held_next     = 1'b1;
                long_rep_next = 1'b0;
                cnt_next      = '0;
            end
            if (held_next) begin
                if (lvl) begin
                    held_next = 1'b0;
                    if (!long_rep_next) begin
                        res_n = 2'd2;
                        code0 = EV_SHORT;
                        code1 = EV_RELEASE;
                    end else begin
                        res_n = 2'd1;
                        code0 = EV_RELEASE;
                    end
                end else if (!long_rep_next && (CW'(cnt_next) >= CW'(long_reg))) begin
                    long_rep_next = 1'b1;
                    res_n         = 2'd1;
                    code0         = EV_LONG;
                end
            end
            poll_cd_next = (poll_reg == 8'd0) ? 8'd0 : poll_reg - 8'd1;
        end
    end

    // Held time as reported, saturated to the result field.
    assign cnt_ext  = CW'(cnt_next);
    assign held_rep = (cnt_ext > CW'({REPORT_W{1'b1}})) ? {REPORT_W{1'b1}}
                                                         : cnt_ext[REPORT_W-1:0];

    // Classifier state update on each processed tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg   <= 1'b1;
            edge_pending_reg <= 1'b0;
            poll_cd_reg      <= 8'd0;
            deb_cd_reg       <= 8'd0;
            debouncing_reg   <= 1'b0;
            held_reg         <= 1'b0;
            long_rep_reg     <= 1'b0;
            cnt_reg          <= '0;
        end else if (process) begin
            prev_level_reg   <= prev_level_next;
            edge_pending_reg <= edge_pending_next;
            poll_cd_reg      <= poll_cd_next;
            deb_cd_reg       <= deb_cd_next;
            debouncing_reg   <= debouncing_next;
            held_reg         <= held_next;
            long_rep_reg     <= long_rep_next;
            cnt_reg          <= cnt_next;
        end
    end

    // Result queue pointers and fill count.
    assign wr_ptr_p1    = wr_ptr_reg + 1'b1;
    assign q_count_next = q_count_reg + (process ? (QPW+1)'(res_n) : '0)
                          - (QPW+1)'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
        end else begin
            q_count_reg <= q_count_next;
            if (process) begin
                wr_ptr_reg <= wr_ptr_reg + QPW'(res_n);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Result queue entries.
    always_ff @(posedge aclk) begin
        if (process && res_n != 2'd0) begin
            q_reg[wr_ptr_reg] <= '{last: (res_n == 2'd1), held_time: held_rep, code: code0};
        end
        if (process && res_n == 2'd2) begin
            q_reg[wr_ptr_p1] <= '{last: 1'b1, held_time: held_rep, code: code1};
        end
    end

    // Result stream outputs from the queue head.
    assign m_tvalid = (q_count_reg != '0);
    assign m_tdata  = {(OUT_TDATA_W - REPORT_W - 2)'(0), q_reg[rd_ptr_reg].held_time,
                       q_reg[rd_ptr_reg].code};
    assign m_tlast  = q_reg[rd_ptr_reg].last;

endmodule

// File: src/bpc_checker.sv
// Port-level assertion checker of the button press classifier and its bind.
`include "assert_macros.svh"

module bpc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [bpc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic                             m_tlast
);
    import bpc_pkg::*;

    // Event code and padding of the offered result.
    logic [1:0]                        out_code;
    logic [OUT_TDATA_W-REPORT_W-3:0]   out_pad;

    assign out_code = m_tdata[1:0];
    assign out_pad  = m_tdata[OUT_TDATA_W-1:REPORT_W+2];

    // A stalled result stays offered.
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

    // A short press is always followed by its release in the same run.
    `ASSERT_IMPLIES(a_short_not_last, aclk, aresetn, m_tvalid && out_code == EV_SHORT, !m_tlast)

    // A release always closes its run.
    `ASSERT_IMPLIES(a_release_last, aclk, aresetn, m_tvalid && out_code == EV_RELEASE, m_tlast)

    // The unused upper bits of a result are zero.
    `ASSERT_IMPLIES(a_pad_zero, aclk, aresetn, m_tvalid, out_pad == '0)

    // The result queue is empty right after reset.
    `ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid)

endmodule

bind button_press_classifier_unit bpc_checker u_bpc_checker (.*);
